@@ rtl/core/ipck_pkg.sv @@
// ----------------------------------------------------------------------------
// ipck_pkg
// Types, codes and helper functions shared by the IPv4 checksum fixer.
// ----------------------------------------------------------------------------
package ipck_pkg;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_TCP  = 2'd1,
    KIND_UDP  = 2'd2,
    KIND_ICMP = 2'd3
  } l4_kind_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_SHORT   = 2'd1,
    STAT_HDR_LEN = 2'd2
  } status_t;

  localparam logic REG_FIX_IP = 1'b0;
  localparam logic REG_FIX_L4 = 1'b1;

  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_UDP  = 8'd17;

  localparam logic [4:0] OFF_TCP  = 5'd16;
  localparam logic [4:0] OFF_UDP  = 5'd6;
  localparam logic [4:0] OFF_ICMP = 5'd2;

  localparam logic [3:0] MIN_HDR_WORDS = 4'd5;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } in_t;

  typedef struct packed {
    logic [15:0] ip_checksum;
    logic        ip_updated;
    logic [15:0] l4_checksum;
    l4_kind_t    l4_kind;
    logic        l4_updated;
    logic [6:0]  l4_checksum_offset;
    status_t     status;
  } out_t;

  // packet totals handed from the accumulator to the final stage
  typedef struct packed {
    logic [15:0] ip_sum;
    logic [15:0] pay_sum;
    logic [15:0] pseudo_sum;
    logic [3:0]  hdr_words;
    logic [15:0] total_len;
    logic [7:0]  proto;
    logic        udp_zero;
    status_t     status;
  } snap_t;

  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    logic [16:0] f;
    s = {1'b0, a} + {1'b0, b};
    f = {1'b0, s[15:0]} + {16'd0, s[16]};
    return f[15:0];
  endfunction

  function automatic l4_kind_t kind_of(input logic [7:0] proto);
    l4_kind_t k;
    priority if (proto == PROTO_TCP) k = KIND_TCP;
    else if (proto == PROTO_UDP) k = KIND_UDP;
    else if (proto == PROTO_ICMP) k = KIND_ICMP;
    else k = KIND_NONE;
    return k;
  endfunction

  function automatic logic [4:0] field_offset(input l4_kind_t kind);
    logic [4:0] o;
    unique case (kind)
      KIND_TCP:  o = OFF_TCP;
      KIND_UDP:  o = OFF_UDP;
      KIND_ICMP: o = OFF_ICMP;
      default:   o = 5'd0;
    endcase
    return o;
  endfunction

endpackage

@@ rtl/core/ipv4_packet_checksum_fixer_top.sv @@
// ----------------------------------------------------------------------------
// ipv4_packet_checksum_fixer_top
// result path: after the last byte, the totals register, then the output register
// throughput: one byte per cycle while the totals register can accept bytes
// a stalled output holds the totals register; bytes keep flowing while it is free
// reset: synchronous, clears all sums and valid flags, both enables return to 1
// ----------------------------------------------------------------------------
module ipv4_packet_checksum_fixer_top (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  ipck_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output ipck_pkg::out_t out_data,
  input  logic           cfg_we,
  input  logic           cfg_index,
  input  logic           cfg_wdata
);
  import ipck_pkg::*;

  logic  fix_ip_r;
  logic  fix_l4_r;
  logic  in_fire;
  logic  snap_valid;
  logic  snap_take;
  snap_t snap;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fix_ip_r <= 1'b1;
      fix_l4_r <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FIX_IP: fix_ip_r <= cfg_wdata;
        REG_FIX_L4: fix_l4_r <= cfg_wdata;
        default:    fix_ip_r <= fix_ip_r;
      endcase
    end
  end

  assign in_ready = !snap_valid || snap_take;
  assign in_fire  = in_valid && in_ready;

  ipck_accum u_accum (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_fire    (in_fire),
    .in_data    (in_data),
    .snap_take  (snap_take),
    .snap_valid (snap_valid),
    .snap       (snap)
  );

  ipck_final u_final (
    .clk        (clk),
    .rst_n      (rst_n),
    .snap_valid (snap_valid),
    .snap       (snap),
    .fix_ip     (fix_ip_r),
    .fix_l4     (fix_l4_r),
    .snap_take  (snap_take),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

@@ rtl/core/ipck_accum.sv @@
// ----------------------------------------------------------------------------
// ipck_accum
// Per-byte running sums and header field capture; registers packet totals
// on the last byte.
// ----------------------------------------------------------------------------
module ipck_accum (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_fire,
  input  ipck_pkg::in_t  in_data,
  input  logic           snap_take,
  output logic           snap_valid,
  output ipck_pkg::snap_t snap
);
  import ipck_pkg::*;

  logic [15:0] pos_r;
  logic [15:0] hsum_r, hsum_nxt;
  logic [15:0] psum_r, psum_nxt;
  logic [15:0] pseudo_r, pseudo_nxt;
  logic [7:0]  hold_r;
  logic [3:0]  hw_r, hw_nxt;
  logic [15:0] tl_r, tl_nxt;
  logic [7:0]  proto_r, proto_nxt;
  logic        udpz_r, udpz_nxt;
  logic        snap_valid_r;
  snap_t       snap_r;

  logic [7:0]  b;
  logic [5:0]  hdr;
  logic [15:0] v;
  logic [15:0] rel;
  l4_kind_t    kind;
  logic [4:0]  off;
  logic [16:0] count;
  status_t     stat;

  assign b = in_data.data_byte;

  always_comb begin
    hw_nxt    = (pos_r == 16'd0) ? b[3:0] : hw_r;
    tl_nxt    = tl_r;
    if (pos_r == 16'd2) tl_nxt = {b, 8'h00};
    if (pos_r == 16'd3) tl_nxt = {tl_r[15:8], b};
    proto_nxt = (pos_r == 16'd9) ? b : proto_r;
    hdr       = {hw_nxt, 2'b00};
    v         = pos_r[0] ? {8'h00, b} : {b, 8'h00};
    rel       = pos_r - {10'd0, hdr};
    kind      = kind_of(proto_nxt);
    off       = field_offset(kind);
    hsum_nxt  = hsum_r;
    psum_nxt  = psum_r;
    pseudo_nxt = pseudo_r;
    udpz_nxt  = udpz_r;
    if (pos_r < {10'd0, hdr}) begin
      if (pos_r != 16'd10 && pos_r != 16'd11) hsum_nxt = oc_add(hsum_r, v);
      if (pos_r >= 16'd12 && pos_r < 16'd20) pseudo_nxt = oc_add(pseudo_r, v);
    end else if (pos_r < tl_nxt) begin
      if (kind != KIND_NONE &&
          (rel == {11'd0, off} || rel == {11'd0, off} + 16'd1)) begin
        if (kind == KIND_UDP && rel == {11'd0, off} + 16'd1 && (hold_r | b) != 8'd0) begin
          udpz_nxt = 1'b0;
        end
      end else begin
        psum_nxt = oc_add(psum_r, v);
      end
    end
    count = {1'b0, pos_r} + 17'd1;
    priority if (hw_nxt < MIN_HDR_WORDS) stat = STAT_HDR_LEN;
    else if (count < {1'b0, tl_nxt} || count < {11'd0, hdr}) stat = STAT_SHORT;
    else stat = STAT_OK;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      hsum_r   <= '0;
      psum_r   <= '0;
      pseudo_r <= '0;
      hold_r   <= '0;
      hw_r     <= '0;
      tl_r     <= '0;
      proto_r  <= '0;
      udpz_r   <= 1'b1;
    end else if (in_fire) begin
      if (in_data.last) begin
        pos_r    <= '0;
        hsum_r   <= '0;
        psum_r   <= '0;
        pseudo_r <= '0;
        hold_r   <= '0;
        hw_r     <= '0;
        tl_r     <= '0;
        proto_r  <= '0;
        udpz_r   <= 1'b1;
      end else begin
        if (pos_r != 16'hFFFF) pos_r <= pos_r + 16'd1;
        hsum_r   <= hsum_nxt;
        psum_r   <= psum_nxt;
        pseudo_r <= pseudo_nxt;
        hold_r   <= b;
        hw_r     <= hw_nxt;
        tl_r     <= tl_nxt;
        proto_r  <= proto_nxt;
        udpz_r   <= udpz_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      snap_valid_r <= 1'b0;
    end else if (in_fire && in_data.last) begin
      snap_valid_r <= 1'b1;
    end else if (snap_take) begin
      snap_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_data.last) begin
      snap_r.ip_sum     <= hsum_nxt;
      snap_r.pay_sum    <= psum_nxt;
      snap_r.pseudo_sum <= pseudo_nxt;
      snap_r.hdr_words  <= hw_nxt;
      snap_r.total_len  <= tl_nxt;
      snap_r.proto      <= proto_nxt;
      snap_r.udp_zero   <= udpz_nxt;
      snap_r.status     <= stat;
    end
  end

  assign snap_valid = snap_valid_r;
  assign snap       = snap_r;

endmodule

@@ rtl/core/ipck_final.sv @@
// ----------------------------------------------------------------------------
// ipck_final
// Folds the packet totals into the header and layer four checksums and
// holds the result in the output register.
// ----------------------------------------------------------------------------
module ipck_final (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            snap_valid,
  input  ipck_pkg::snap_t snap,
  input  logic            fix_ip,
  input  logic            fix_l4,
  output logic            snap_take,
  output logic            out_valid,
  input  logic            out_ready,
  output ipck_pkg::out_t  out_data
);
  import ipck_pkg::*;

  logic        out_valid_r;
  out_t        out_data_r;
  out_t        res;
  logic        advance;
  logic [5:0]  hdr;
  l4_kind_t    kind;
  logic        l4_ok;
  logic [15:0] l4_len;
  logic [17:0] total;
  logic [16:0] fold1;
  logic [15:0] fold2;
  logic [15:0] csum;
  logic [6:0]  off_full;

  always_comb begin
    hdr      = {snap.hdr_words, 2'b00};
    kind     = kind_of(snap.proto);
    l4_ok    = fix_l4 && kind != KIND_NONE && snap.total_len >= {10'd0, hdr};
    l4_len   = snap.total_len - {10'd0, hdr};
    total    = {2'd0, snap.pseudo_sum} + {10'd0, snap.proto} + {2'd0, l4_len}
             + {2'd0, snap.pay_sum};
    fold1    = {1'b0, total[15:0]} + {15'd0, total[17:16]};
    fold2    = fold1[15:0] + {15'd0, fold1[16]};
    csum     = ~fold2;
    off_full = {1'b0, hdr} + {2'd0, field_offset(kind)};

    res = '0;
    res.status = snap.status;
    if (snap.status == STAT_OK) begin
      if (fix_ip) begin
        res.ip_checksum = ~snap.ip_sum;
        res.ip_updated  = 1'b1;
      end
      if (l4_ok) begin
        res.l4_kind            = kind;
        res.l4_checksum_offset = off_full;
        unique case (kind)
          KIND_ICMP: begin
            res.l4_checksum = ~snap.pay_sum;
            res.l4_updated  = 1'b1;
          end
          KIND_UDP: begin
            if (!snap.udp_zero) begin
              res.l4_checksum = (csum == 16'd0) ? 16'hFFFF : csum;
              res.l4_updated  = 1'b1;
            end
          end
          default: begin
            res.l4_checksum = csum;
            res.l4_updated  = 1'b1;
          end
        endcase
      end
    end
  end

  assign advance   = !out_valid_r || out_ready;
  assign snap_take = snap_valid && advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= snap_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_take) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
